### src/frcr_pkg.sv
// ----------------------------------------------------------------------------
// frcr_pkg
// Shared codes, result type and header byte layout for the framed capture
// ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package frcr_pkg;

  // request function codes
  localparam logic [1:0] FUNC_HDR   = 2'd0;
  localparam logic [1:0] FUNC_PAY   = 2'd1;
  localparam logic [1:0] FUNC_DRAIN = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_PAY   = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam int FREE_W     = 13;
  localparam int HDR_CNT_W  = 4;
  localparam int HDR_BYTES  = 12;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_BYTES - 1);

  localparam logic [7:0] MAGIC_0 = 8'h50;
  localparam logic [7:0] MAGIC_1 = 8'h44;
  localparam logic [7:0] MAGIC_2 = 8'h4B;
  localparam logic [7:0] MAGIC_3 = 8'h46;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [7:0]        data;
    logic              last;
    logic [31:0]       frames;
    logic [FREE_W-1:0] free;
  } frcr_result_t;

  // byte idx of the 12-byte frame header
  function automatic logic [7:0] hdr_byte(input logic [HDR_CNT_W-1:0] idx,
                                          input logic [31:0] ts,
                                          input logic [7:0] iface,
                                          input logic [7:0] role,
                                          input logic [15:0] len);
    logic [7:0] b;
    case (idx)
      4'd0:    b = MAGIC_0;
      4'd1:    b = MAGIC_1;
      4'd2:    b = MAGIC_2;
      4'd3:    b = MAGIC_3;
      4'd4:    b = ts[7:0];
      4'd5:    b = ts[15:8];
      4'd6:    b = ts[23:16];
      4'd7:    b = ts[31:24];
      4'd8:    b = iface;
      4'd9:    b = role;
      4'd10:   b = len[7:0];
      4'd11:   b = len[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### src/frcr_ram.sv
// ----------------------------------------------------------------------------
// frcr_ram
// Byte ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module frcr_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/frcr_seq.sv
// ----------------------------------------------------------------------------
// frcr_seq
// Request sequencer: admission checks, header serialization, payload store,
// chunked drain and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module frcr_seq #(
  parameter int RING_DEPTH  = 8192,
  parameter int CHUNK_BYTES = 64,
  parameter int PW          = $clog2(RING_DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic                    cfg_wr_data,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              in_func,
  input  wire logic [31:0]             in_timestamp,
  input  wire logic [7:0]              in_iface,
  input  wire logic [7:0]              in_role,
  input  wire logic [15:0]             in_frame_length,
  input  wire logic [7:0]              in_payload_byte,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output frcr_pkg::frcr_result_t       out_res,
  output logic                         ram_we,
  output logic [PW-1:0]                ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic                         ram_re,
  output logic [PW-1:0]                ram_raddr,
  input  wire logic [7:0]              ram_rdata
);

  import frcr_pkg::*;

  localparam int CW = $clog2(CHUNK_BYTES + 1);
  localparam int FW = (PW > FREE_W) ? PW : FREE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_EMIT,
    S_DRN_RD,
    S_DRN_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic                 en_r, en_nxt;
  logic [31:0]          frames_r, frames_nxt;
  logic [15:0]          owed_r, owed_nxt;
  logic [PW-1:0]        wp_r, wp_nxt;
  logic [PW-1:0]        rp_r, rp_nxt;
  logic [PW-1:0]        free_r, free_nxt;
  logic                 out_valid_r, out_valid_nxt;
  frcr_result_t         res_r, res_nxt;

  logic [31:0]          ts_r, ts_nxt;
  logic [7:0]           iface_r, iface_nxt;
  logic [7:0]           role_r, role_nxt;
  logic [15:0]          len_r, len_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic [1:0]           st_r, st_nxt;
  logic [HDR_CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [CW-1:0]        ccnt_r, ccnt_nxt;
  logic                 fin_r, fin_nxt;

  logic                 slot_free;
  logic [16:0]          need;
  logic [PW-1:0]        rp_inc;
  logic [FW-1:0]        free_ext;
  logic [FREE_W-1:0]    free13;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign need      = 17'(HDR_BYTES) + 17'(in_frame_length);
  assign rp_inc    = ptr_inc(rp_r);
  assign free_ext  = FW'(free_r);
  assign free13    = free_ext[FREE_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    en_nxt        = en_r;
    frames_nxt    = frames_r;
    owed_nxt      = owed_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    ts_nxt        = ts_r;
    iface_nxt     = iface_r;
    role_nxt      = role_r;
    len_nxt       = len_r;
    kind_nxt      = kind_r;
    st_nxt        = st_r;
    hcnt_nxt      = hcnt_r;
    ccnt_nxt      = ccnt_r;
    fin_nxt       = fin_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = 8'h00;
    ram_re        = 1'b0;
    ram_raddr     = rp_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // enabling recording restarts the frame count
    if (cfg_wr_en) begin
      if (!en_r && cfg_wr_data) begin
        frames_nxt = '0;
      end
      en_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_HDR) begin
            ts_nxt    = in_timestamp;
            iface_nxt = in_iface;
            role_nxt  = in_role;
            len_nxt   = in_frame_length;
            kind_nxt  = KIND_HDR;
            hcnt_nxt  = '0;
            priority if (!en_r) begin
              st_nxt    = ST_DISABLED;
              state_nxt = S_EMIT;
            end else if (owed_r != '0) begin
              st_nxt    = ST_IGNORED;
              state_nxt = S_EMIT;
            end else if (17'(free_r) < need) begin
              st_nxt    = ST_NO_SPACE;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_HDR;
            end
          end else if (in_func == FUNC_PAY) begin
            kind_nxt  = KIND_PAY;
            state_nxt = S_EMIT;
            if (owed_r != '0 && free_r != '0) begin
              ram_we    = 1'b1;
              ram_wdata = in_payload_byte;
              wp_nxt    = ptr_inc(wp_r);
              free_nxt  = free_r - 1'b1;
              owed_nxt  = owed_r - 1'b1;
              st_nxt    = ST_OK;
            end else begin
              st_nxt    = ST_IGNORED;
            end
          end else if (in_func == FUNC_DRAIN) begin
            // empty ring: drop the request without a result
            if (rp_r != wp_r) begin
              ccnt_nxt  = '0;
              state_nxt = S_DRN_RD;
            end
          end
        end
      end

      S_HDR: begin
        ram_we    = 1'b1;
        ram_wdata = hdr_byte(hcnt_r, ts_r, iface_r, role_r, len_r);
        wp_nxt    = ptr_inc(wp_r);
        free_nxt  = free_r - 1'b1;
        hcnt_nxt  = hcnt_r + 1'b1;
        if (hcnt_r == HDR_LAST) begin
          frames_nxt = frames_r + 32'd1;
          owed_nxt   = len_r;
          st_nxt     = ST_OK;
          state_nxt  = S_EMIT;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          res_nxt.kind   = kind_r;
          res_nxt.status = st_r;
          res_nxt.data   = 8'h00;
          res_nxt.last   = 1'b1;
          res_nxt.frames = frames_r;
          res_nxt.free   = free13;
          state_nxt      = S_IDLE;
        end
      end

      S_DRN_RD: begin
        ram_re    = 1'b1;
        rp_nxt    = rp_inc;
        free_nxt  = free_r + 1'b1;
        fin_nxt   = (ccnt_r == CW'(CHUNK_BYTES - 1)) || (rp_inc == wp_r);
        ccnt_nxt  = ccnt_r + 1'b1;
        state_nxt = S_DRN_OUT;
      end

      S_DRN_OUT: begin
        // hold read data until the output register frees up
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          res_nxt.kind   = KIND_DRAIN;
          res_nxt.status = ST_OK;
          res_nxt.data   = ram_rdata;
          res_nxt.last   = fin_r;
          res_nxt.frames = frames_r;
          res_nxt.free   = free13;
          state_nxt      = fin_r ? S_IDLE : S_DRN_RD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      frames_r    <= '0;
      owed_r      <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      free_r      <= PW'(RING_DEPTH - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      frames_r    <= frames_nxt;
      owed_r      <= owed_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r   <= res_nxt;
    ts_r    <= ts_nxt;
    iface_r <= iface_nxt;
    role_r  <= role_nxt;
    len_r   <= len_nxt;
    kind_r  <= kind_nxt;
    st_r    <= st_nxt;
    hcnt_r  <= hcnt_nxt;
    ccnt_r  <= ccnt_nxt;
    fin_r   <= fin_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### src/framed_capture_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// framed_capture_ring_buffer_unit
// Frame capture buffer that serializes headers and payload into a byte ring.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A payload request stores its byte and
// then gives a status. An admitted header writes its 12 header bytes
// through the single ring write port, one per cycle; a rejected header only
// gives its status. A drain alternates a read and an output step per byte,
// up to CHUNK_BYTES bytes, paced by the registered read port of the ring; a
// drain of an empty ring gives no result. Results pass through one output
// register, so a request may be taken while the previous result still waits.
// The ring holds at most RING_DEPTH-1 bytes and needs no clearing after reset.
`default_nettype none

module framed_capture_ring_buffer_unit #(
  parameter int RING_DEPTH  = 8192,
  parameter int CHUNK_BYTES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_func,
  input  wire logic [31:0]                 in_timestamp,
  input  wire logic [7:0]                  in_iface,
  input  wire logic [7:0]                  in_role,
  input  wire logic [15:0]                 in_frame_length,
  input  wire logic [7:0]                  in_payload_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_kind,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_byte,
  output logic                             out_last,
  output logic [31:0]                      out_frames_counted,
  output logic [frcr_pkg::FREE_W-1:0]      out_free_bytes
);

  import frcr_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);

  frcr_result_t  res;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [PW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  frcr_seq #(
    .RING_DEPTH  (RING_DEPTH),
    .CHUNK_BYTES (CHUNK_BYTES),
    .PW          (PW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_timestamp    (in_timestamp),
    .in_iface        (in_iface),
    .in_role         (in_role),
    .in_frame_length (in_frame_length),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_res         (res),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  frcr_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_kind           = res.kind;
  assign out_status         = res.status;
  assign out_byte           = res.data;
  assign out_last           = res.last;
  assign out_frames_counted = res.frames;
  assign out_free_bytes     = res.free;

endmodule

`default_nettype wire

### src/frcr_checker.sv
// ----------------------------------------------------------------------------
// frcr_checker
// Port-level checks for the framed capture ring buffer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module frcr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_byte,
  input wire logic        out_last
);

  import frcr_pkg::*;

  // drained bytes always carry the accepted status
  a_drain_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DRAIN |-> out_status == ST_OK)
    else $error("drained byte with nonzero status");

  // status results close their request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DRAIN |-> out_last)
    else $error("status result without last");

  a_status_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DRAIN |-> out_byte == 8'h00)
    else $error("status result with nonzero byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind framed_capture_ring_buffer_unit frcr_checker u_frcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_kind   (out_kind),
  .out_status (out_status),
  .out_byte   (out_byte),
  .out_last   (out_last)
);

`default_nettype wire
